>>> rtl/tbrc_pkg.sv
`default_nettype none
package tbrc_pkg;
  localparam int MAP_W_DEF = 64;
  localparam int MAP_H_DEF = 64;
  localparam int TILE_W_DEF = 16;
  localparam int TILE_H_DEF = 16;
  localparam int TILESET_COLS_DEF = 16;
  localparam int TILE_BITS_DEF = 10;

  localparam int VW = 48;
  localparam int QW = 24;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  localparam logic [2:0] REG_SCALE_X = 3'd0;
  localparam logic [2:0] REG_SCALE_Y = 3'd1;
  localparam logic [2:0] REG_VIEW_X = 3'd2;
  localparam logic [2:0] REG_VIEW_Y = 3'd3;
  localparam logic [2:0] REG_VIEW_W = 3'd4;
  localparam logic [2:0] REG_VIEW_H = 3'd5;
  localparam logic [2:0] REG_SCROLL_X = 3'd6;
  localparam logic [2:0] REG_SCROLL_Y = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_TILE, ST_MULX, ST_MULY, ST_ADD,
    ST_LEFT, ST_TOP, ST_RIGHT, ST_BOTTOM, ST_DIV, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE, CMD_TILE, CMD_MULX, CMD_MULY, CMD_ADD, CMD_EDGE, CMD_DIVSTEP, CMD_FIN
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [1:0] edge_sel;
    logic       div_start;
  } cmd_t;

  typedef struct packed {
    logic edge_hit;
    logic div_done;
  } status_t;
endpackage
`default_nettype wire

>>> rtl/tbrc_ram.sv
`default_nettype none
module tbrc_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/tbrc_ctrl.sv
`default_nettype none
module tbrc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            operation,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire tbrc_pkg::status_t st,
  output tbrc_pkg::cmd_t       cmd
);
  import tbrc_pkg::*;

  state_t     state, state_next;
  logic [1:0] edge_cur, edge_cur_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      edge_cur <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      edge_cur <= edge_cur_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    edge_cur_next = edge_cur;
    out_valid_next = out_valid && !out_ready;
    in_ready = 1'b0;
    cmd = '{op: CMD_NONE, edge_sel: edge_cur, div_start: 1'b0};
    unique case (state) inside
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && operation == OP_PLACE) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_TILE;
      ST_TILE: begin
        cmd.op = CMD_TILE;
        state_next = ST_MULX;
      end
      ST_MULX: begin
        cmd.op = CMD_MULX;
        state_next = ST_MULY;
      end
      ST_MULY: begin
        cmd.op = CMD_MULY;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.op = CMD_ADD;
        edge_cur_next = 2'd0;
        state_next = ST_LEFT;
      end
      ST_LEFT, ST_TOP, ST_RIGHT, ST_BOTTOM: begin
        cmd.edge_sel = edge_cur;
        if (st.edge_hit) begin
          cmd.div_start = 1'b1;
          state_next = ST_DIV;
        end else if (edge_cur == 2'd3) begin
          state_next = ST_OUT;
        end else begin
          edge_cur_next = edge_cur + 2'd1;
        end
      end
      ST_DIV: begin
        cmd.op = CMD_DIVSTEP;
        if (st.div_done) begin
          cmd.op = CMD_EDGE;
          if (edge_cur == 2'd3) begin
            state_next = ST_OUT;
          end else begin
            edge_cur_next = edge_cur + 2'd1;
            state_next = ST_LEFT;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.op = CMD_FIN;
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/tbrc_dp.sv
`default_nettype none
module tbrc_dp #(
  parameter int MAP_W = tbrc_pkg::MAP_W_DEF,
  parameter int MAP_H = tbrc_pkg::MAP_H_DEF,
  parameter int TILE_W = tbrc_pkg::TILE_W_DEF,
  parameter int TILE_H = tbrc_pkg::TILE_H_DEF,
  parameter int TILESET_COLS = tbrc_pkg::TILESET_COLS_DEF,
  parameter int TILE_BITS = tbrc_pkg::TILE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  accept,
  input  wire logic                  operation,
  input  wire logic signed [6:0]     map_x,
  input  wire logic signed [6:0]     map_y,
  input  wire logic [9:0]            tile_value,
  input  wire logic [4:0]            scale_x,
  input  wire logic [4:0]            scale_y,
  input  wire logic [11:0]           view_x,
  input  wire logic [11:0]           view_y,
  input  wire logic [12:0]           view_w,
  input  wire logic [12:0]           view_h,
  input  wire logic signed [15:0]    scroll_x,
  input  wire logic signed [15:0]    scroll_y,
  input  wire tbrc_pkg::cmd_t        cmd,
  output tbrc_pkg::status_t          st,
  output logic signed [15:0]         src_x,
  output logic signed [15:0]         src_y,
  output logic signed [15:0]         src_w,
  output logic signed [15:0]         src_h,
  output logic signed [15:0]         dst_x,
  output logic signed [15:0]         dst_y,
  output logic signed [15:0]         dst_w,
  output logic signed [15:0]         dst_h
);
  import tbrc_pkg::*;

  localparam int CELLS = MAP_W * MAP_H;
  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic signed [6:0] mx, my;
  logic              inmap_r;
  logic [5:0]        sxe, sye;
  logic signed [VW-1:0] sx, sy, sw, sh, dx, dy, dw, dh, px, py;
  logic signed [VW-1:0] vx, vy, vr, vb;
  logic [QW-1:0]     num, quo;
  logic [5:0]        rem, dvs;
  logic [4:0]        cnt;
  logic [TILE_BITS-1:0] rd;

  function automatic logic in_map_f(logic signed [6:0] x, logic signed [6:0] y);
    return (x >= 0) && (32'(x) < MAP_W) && (y >= 0) && (32'(y) < MAP_H);
  endfunction

  logic          we;
  logic [AW-1:0] waddr, raddr;

  assign we = accept && operation == OP_WRITE && in_map_f(map_x, map_y);
  assign waddr = AW'(32'(map_x) + 32'(map_y) * MAP_W);
  assign raddr = AW'(32'(mx) + 32'(my) * MAP_W);

  tbrc_ram #(.WIDTH(TILE_BITS), .DEPTH(CELLS)) u_map (
    .clk(clk), .we(we), .waddr(waddr), .wdata(tile_value[TILE_BITS-1:0]),
    .raddr(raddr), .rdata(rd)
  );

  assign vx = VW'(view_x);
  assign vy = VW'(view_y);
  assign vr = vx + VW'(view_w);
  assign vb = vy + VW'(view_h);

  logic [TILE_BITS-1:0] idx;
  assign idx = inmap_r ? rd : '0;

  logic signed [VW-1:0] d_over, e_num;
  logic [5:0] e_div;
  always_comb begin
    st.edge_hit = 1'b0;
    st.div_done = (cnt == 5'd0);
    e_num = '0;
    e_div = sxe;
    case (cmd.edge_sel)
      2'd0: begin
        st.edge_hit = dx < vx; e_num = vx - dx; e_div = sxe;
      end
      2'd1: begin
        st.edge_hit = dy < vy; e_num = vy - dy; e_div = sye;
      end
      2'd2: begin
        st.edge_hit = dx + dw > vr; e_num = vr - dx; e_div = sxe;
      end
      default: begin
        st.edge_hit = dy + dh > vb; e_num = vb - dy; e_div = sye;
      end
    endcase
    d_over = e_num;
  end

  // Right and bottom numerators may be negative; magnitude is divided and the sign restored.
  logic neg;
  logic [QW-1:0] mag;
  assign mag = d_over[VW-1] ? QW'(-d_over) : QW'(d_over);

  logic [6:0] trial;
  assign trial = {rem, num[QW-1]} - {1'b0, dvs};

  logic signed [VW-1:0] q;
  assign q = neg ? -VW'(quo) : VW'(quo);

  always_ff @(posedge clk) begin
    if (accept) begin
      mx <= map_x;
      my <= map_y;
      inmap_r <= in_map_f(map_x, map_y);
      sxe <= (scale_x == 5'd0) ? 6'd1 : {1'b0, scale_x};
      sye <= (scale_y == 5'd0) ? 6'd1 : {1'b0, scale_y};
    end
    if (cmd.div_start) begin
      num <= mag;
      neg <= d_over[VW-1];
      dvs <= e_div;
      rem <= '0;
      quo <= '0;
      cnt <= 5'(QW);
    end
    case (cmd.op)
      CMD_TILE: begin
        sx <= VW'(32'(idx) % TILESET_COLS * TILE_W);
        sy <= VW'(32'(idx) / TILESET_COLS * TILE_H);
        sw <= VW'(TILE_W);
        sh <= VW'(TILE_H);
        px <= VW'(32'(mx) * TILE_W) + VW'(scroll_x);
        py <= VW'(32'(my) * TILE_H) + VW'(scroll_y);
      end
      CMD_MULX: begin
        dx <= px * VW'(sxe);
        dw <= VW'(TILE_W) * VW'(sxe);
      end
      CMD_MULY: begin
        dy <= py * VW'(sye);
        dh <= VW'(TILE_H) * VW'(sye);
      end
      CMD_ADD: begin
        dx <= dx + vx;
        dy <= dy + vy;
      end
      CMD_DIVSTEP: begin
        if (cnt != 5'd0) begin
          if (!trial[6]) begin
            rem <= trial[5:0];
            quo <= {quo[QW-2:0], 1'b1};
          end else begin
            rem <= {rem[4:0], num[QW-1]};
            quo <= {quo[QW-2:0], 1'b0};
          end
          num <= {num[QW-2:0], 1'b0};
          cnt <= cnt - 5'd1;
        end
      end
      CMD_EDGE: begin
        case (cmd.edge_sel)
          2'd0: begin
            sw <= sw - q; sx <= sx + q; dw <= dw - (vx - dx); dx <= vx;
          end
          2'd1: begin
            sh <= sh - q; sy <= sy + q; dh <= dh - (vy - dy); dy <= vy;
          end
          2'd2: begin
            sw <= q; dw <= vr - dx;
          end
          default: begin
            sh <= q; dh <= vb - dy;
          end
        endcase
      end
      CMD_FIN: begin
        src_x <= sx[15:0]; src_y <= sy[15:0]; src_w <= sw[15:0]; src_h <= sh[15:0];
        dst_x <= dx[15:0]; dst_y <= dy[15:0]; dst_w <= dw[15:0]; dst_h <= dh[15:0];
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/tile_blit_rect_clip.sv
// Write items give no result.
// Place items pass through read, tile lookup, scaling, offset and edge checks; each clipped
// edge runs a 24-step radix-2 divider, and a result held at the output adds its stall.
// Throughput is one item at a time, set by the shared divider; a result may wait in the
// output register while the next item is accepted.
// Synchronous reset restores control and config registers to defaults; the tile map is undefined until written.
`default_nettype none
module tile_blit_rect_clip #(
  parameter int MAP_W = tbrc_pkg::MAP_W_DEF,
  parameter int MAP_H = tbrc_pkg::MAP_H_DEF,
  parameter int TILE_W = tbrc_pkg::TILE_W_DEF,
  parameter int TILE_H = tbrc_pkg::TILE_H_DEF,
  parameter int TILESET_COLS = tbrc_pkg::TILESET_COLS_DEF,
  parameter int TILE_BITS = tbrc_pkg::TILE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               operation,
  input  wire logic signed [6:0]  map_x,
  input  wire logic signed [6:0]  map_y,
  input  wire logic [9:0]         tile_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      src_x,
  output logic signed [15:0]      src_y,
  output logic signed [15:0]      src_w,
  output logic signed [15:0]      src_h,
  output logic signed [15:0]      dst_x,
  output logic signed [15:0]      dst_y,
  output logic signed [15:0]      dst_w,
  output logic signed [15:0]      dst_h,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import tbrc_pkg::*;

  logic [4:0] scale_x, scale_y;
  logic [11:0] view_x, view_y;
  logic [12:0] view_w, view_h;
  logic signed [15:0] scroll_x, scroll_y;
  logic [2:0] reg_sel;
  cmd_t cmd;
  status_t st;

  assign pready = 1'b1;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x <= 5'd1; scale_y <= 5'd1;
      view_x <= '0; view_y <= '0;
      view_w <= 13'd640; view_h <= 13'd480;
      scroll_x <= '0; scroll_y <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_SCALE_X: scale_x <= pwdata[4:0];
        REG_SCALE_Y: scale_y <= pwdata[4:0];
        REG_VIEW_X: view_x <= pwdata[11:0];
        REG_VIEW_Y: view_y <= pwdata[11:0];
        REG_VIEW_W: view_w <= pwdata[12:0];
        REG_VIEW_H: view_h <= pwdata[12:0];
        REG_SCROLL_X: scroll_x <= pwdata[15:0];
        REG_SCROLL_Y: scroll_y <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SCALE_X: prdata = {27'd0, scale_x};
      REG_SCALE_Y: prdata = {27'd0, scale_y};
      REG_VIEW_X: prdata = {20'd0, view_x};
      REG_VIEW_Y: prdata = {20'd0, view_y};
      REG_VIEW_W: prdata = {19'd0, view_w};
      REG_VIEW_H: prdata = {19'd0, view_h};
      REG_SCROLL_X: prdata = {{16{scroll_x[15]}}, scroll_x};
      REG_SCROLL_Y: prdata = {{16{scroll_y[15]}}, scroll_y};
      default: prdata = '0;
    endcase
  end

  tbrc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .operation(operation),
    .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
    .st(st), .cmd(cmd)
  );

  tbrc_dp #(
    .MAP_W(MAP_W), .MAP_H(MAP_H), .TILE_W(TILE_W), .TILE_H(TILE_H),
    .TILESET_COLS(TILESET_COLS), .TILE_BITS(TILE_BITS)
  ) u_dp (
    .clk(clk), .accept(in_valid && in_ready), .operation(operation),
    .map_x(map_x), .map_y(map_y), .tile_value(tile_value),
    .scale_x(scale_x), .scale_y(scale_y), .view_x(view_x), .view_y(view_y),
    .view_w(view_w), .view_h(view_h), .scroll_x(scroll_x), .scroll_y(scroll_y),
    .cmd(cmd), .st(st),
    .src_x(src_x), .src_y(src_y), .src_w(src_w), .src_h(src_h),
    .dst_x(dst_x), .dst_y(dst_y), .dst_w(dst_w), .dst_h(dst_h)
  );
endmodule
`default_nettype wire
